// ===== design/pipt_pkg.sv =====
package pipt_pkg;

    // Operation codes of an input transaction
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TEST   = 2'd2;

    // Configuration register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_RADIUS_EN = 2'd0;
    localparam logic [1:0] REG_CENTER_X  = 2'd1;
    localparam logic [1:0] REG_CENTER_Y  = 2'd2;
    localparam logic [1:0] REG_RADIUS_SQ = 2'd3;

    // Configuration port geometry and register widths
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int CENTER_W   = 16;
    localparam int RADIUS_W   = 33;

    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

endpackage

// ===== design/point_in_polygon_test_unit.sv =====
// Clear and append: the result strobes in the cycle after the transaction is accepted.
// Test: busy through the optional radius check (S_CX, S_CY, S_CCMP), S_BEGIN, S_FETCH and
//   S_EDGE per stored vertex, S_CLOSE, and S_MUL1, S_MUL2, S_CMP per edge that reaches the
//   cross-multiply on the one shared multiplier; an empty store or rejected point ends early.
// The result strobes in the first cycle with busy low.
// Results are never stalled: o_done is high for exactly one cycle per transaction.
// Synchronous reset empties the store and clears control state; vertex memory is not cleared.
module point_in_polygon_test_unit #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic [1:0]                           i_operation,
    input  logic signed [COORD_WIDTH-1:0]        i_coord_x,
    input  logic signed [COORD_WIDTH-1:0]        i_coord_y,
    output logic                                 o_done,
    output logic                                 o_inside_res,
    output logic                                 o_status,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pipt_pkg::CFG_ADDR_W-1:0]      paddr,
    input  pipt_pkg::t_cfg_data                  pwdata,
    output pipt_pkg::t_cfg_data                  prdata,
    output logic                                 pready
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int DW = ((COORD_WIDTH > pipt_pkg::CENTER_W) ? COORD_WIDTH
                                                             : pipt_pkg::CENTER_W) + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CX    = 4'd1;
    localparam logic [3:0] S_CY    = 4'd2;
    localparam logic [3:0] S_CCMP  = 4'd3;
    localparam logic [3:0] S_BEGIN = 4'd4;
    localparam logic [3:0] S_FETCH = 4'd5;
    localparam logic [3:0] S_EDGE  = 4'd6;
    localparam logic [3:0] S_CLOSE = 4'd7;
    localparam logic [3:0] S_MUL1  = 4'd8;
    localparam logic [3:0] S_MUL2  = 4'd9;
    localparam logic [3:0] S_CMP   = 4'd10;

    // Control and configuration
    logic [3:0]                          r_state;
    logic [CW-1:0]                       r_count;
    logic [CW-1:0]                       r_idx;
    logic                                r_parity;
    logic                                r_closing;
    logic                                r_done;
    logic                                r_inside;
    logic                                r_status;
    logic                                r_rad_en;
    logic signed [pipt_pkg::CENTER_W-1:0] r_cx;
    logic signed [pipt_pkg::CENTER_W-1:0] r_cy;
    logic [pipt_pkg::RADIUS_W-1:0]       r_rad_sq;

    // Payload
    logic signed [COORD_WIDTH-1:0]       r_px, r_py;
    logic signed [COORD_WIDTH-1:0]       r_fx, r_fy;
    logic signed [COORD_WIDTH-1:0]       r_vx, r_vy;
    logic signed [COORD_WIDTH-1:0]       r_ax, r_ay, r_bx, r_by;
    logic signed [COORD_WIDTH-1:0]       r_rd_x, r_rd_y;
    logic signed [PW-1:0]                r_prod1, r_prod2;

    // Vertex store
    logic signed [COORD_WIDTH-1:0]       mem_x [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0]       mem_y [MAX_VERTICES];

    logic                                accept;
    logic                                full;
    logic                                wr_en;
    logic                                cfg_wr;
    logic signed [COORD_WIDTH-1:0]       e_bx, e_by;
    logic                                e_skip;
    logic                                e_swap;
    logic signed [DW-1:0]                m_a, m_b;
    logic signed [PW-1:0]                m_p;
    logic [SW-1:0]                       dist_sq;
    logic                                outside;
    logic [CW-1:0]                       idx_inc;
    logic                                last;
    logic                                parity_n;

    assign accept  = i_start && !o_busy;
    assign full    = (r_count == CW'(MAX_VERTICES));
    assign wr_en   = accept && (i_operation == pipt_pkg::OP_APPEND) && !full;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign idx_inc = r_idx + 1'b1;
    assign last    = (idx_inc == r_count);

    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_inside_res = r_inside;
    assign o_status     = r_status;
    assign pready       = 1'b1;

    // Store vertices on append
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_x[r_count[AW-1:0]] <= i_coord_x;
            mem_y[r_count[AW-1:0]] <= i_coord_y;
        end
    end

    // Read one vertex per cycle at the walk index
    always_ff @(posedge i_clk) begin
        r_rd_x <= mem_x[r_idx[AW-1:0]];
        r_rd_y <= mem_y[r_idx[AW-1:0]];
    end

    // Edge under test: previous vertex to the fetched one, or last back to first
    assign e_bx = (r_state == S_CLOSE) ? r_fx : r_rd_x;
    assign e_by = (r_state == S_CLOSE) ? r_fy : r_rd_y;

    always_comb begin
        e_skip = (r_vy == e_by)
              || ((r_vx < r_px) && (e_bx < r_px))
              || ((r_vy >= r_py) && (e_by >= r_py))
              || ((r_vy < r_py) && (e_by < r_py));
        e_swap = (r_vy > e_by);
    end

    // Shared multiplier operand select
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            S_CX: begin
                m_a = DW'(r_px) - DW'(r_cx);
                m_b = DW'(r_px) - DW'(r_cx);
            end
            S_CY: begin
                m_a = DW'(r_py) - DW'(r_cy);
                m_b = DW'(r_py) - DW'(r_cy);
            end
            S_MUL1: begin
                m_a = DW'(r_px) - DW'(r_ax);
                m_b = DW'(r_by) - DW'(r_ay);
            end
            S_MUL2: begin
                m_a = DW'(r_bx) - DW'(r_ax);
                m_b = DW'(r_py) - DW'(r_ay);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign m_p = m_a * m_b;

    // Squared distance against the circle; cross-product parity update
    assign dist_sq  = SW'($unsigned(r_prod1)) + SW'($unsigned(r_prod2));
    assign outside  = (dist_sq > SW'(r_rad_sq));
    assign parity_n = r_parity ^ !(r_prod1 > r_prod2);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad_en <= 1'b0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_rad_sq <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[4:3])
                pipt_pkg::REG_RADIUS_EN: r_rad_en <= pwdata[0];
                pipt_pkg::REG_CENTER_X:  r_cx     <= pwdata[pipt_pkg::CENTER_W-1:0];
                pipt_pkg::REG_CENTER_Y:  r_cy     <= pwdata[pipt_pkg::CENTER_W-1:0];
                pipt_pkg::REG_RADIUS_SQ: r_rad_sq <= pwdata[pipt_pkg::RADIUS_W-1:0];
                default:                 r_rad_en <= r_rad_en;
            endcase
        end
    end

    // Configuration reads
    always_comb begin
        unique case (paddr[4:3])
            pipt_pkg::REG_RADIUS_EN:
                prdata = pipt_pkg::t_cfg_data'(r_rad_en);
            pipt_pkg::REG_CENTER_X:
                prdata = pipt_pkg::t_cfg_data'($unsigned(r_cx));
            pipt_pkg::REG_CENTER_Y:
                prdata = pipt_pkg::t_cfg_data'($unsigned(r_cy));
            pipt_pkg::REG_RADIUS_SQ:
                prdata = pipt_pkg::t_cfg_data'(r_rad_sq);
            default:
                prdata = '0;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_parity  <= 1'b0;
            r_closing <= 1'b0;
            r_done    <= 1'b0;
            r_inside  <= 1'b0;
            r_status  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_inside <= 1'b0;
                        r_status <= 1'b0;
                        case (i_operation)
                            pipt_pkg::OP_CLEAR: begin
                                r_count <= '0;
                                r_done  <= 1'b1;
                            end
                            pipt_pkg::OP_APPEND: begin
                                if (full) begin
                                    r_status <= 1'b1;
                                end else begin
                                    r_count <= r_count + 1'b1;
                                end
                                r_done <= 1'b1;
                            end
                            pipt_pkg::OP_TEST: begin
                                r_px      <= i_coord_x;
                                r_py      <= i_coord_y;
                                r_parity  <= 1'b0;
                                r_closing <= 1'b0;
                                r_idx     <= '0;
                                r_state   <= r_rad_en ? S_CX : S_BEGIN;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_CX: begin
                    r_prod1 <= m_p;
                    r_state <= S_CY;
                end
                S_CY: begin
                    r_prod2 <= m_p;
                    r_state <= S_CCMP;
                end
                S_CCMP: begin
                    if (outside) begin
                        r_inside <= 1'b0;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_BEGIN;
                    end
                end
                S_BEGIN: begin
                    if (r_count == '0) begin
                        r_inside <= 1'b0;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    r_vx <= r_rd_x;
                    r_vy <= r_rd_y;
                    if (r_idx == '0) begin
                        // first vertex: keep it for the closing edge
                        r_fx    <= r_rd_x;
                        r_fy    <= r_rd_y;
                        r_idx   <= idx_inc;
                        r_state <= last ? S_CLOSE : S_FETCH;
                    end else if (e_skip) begin
                        r_idx   <= idx_inc;
                        r_state <= last ? S_CLOSE : S_FETCH;
                    end else begin
                        r_ax    <= e_swap ? e_bx : r_vx;
                        r_ay    <= e_swap ? e_by : r_vy;
                        r_bx    <= e_swap ? r_vx : e_bx;
                        r_by    <= e_swap ? r_vy : e_by;
                        r_state <= S_MUL1;
                    end
                end
                S_CLOSE: begin
                    if (e_skip) begin
                        r_inside <= r_parity;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_ax      <= e_swap ? e_bx : r_vx;
                        r_ay      <= e_swap ? e_by : r_vy;
                        r_bx      <= e_swap ? r_vx : e_bx;
                        r_by      <= e_swap ? r_vy : e_by;
                        r_closing <= 1'b1;
                        r_state   <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_prod1 <= m_p;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod2 <= m_p;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_parity <= parity_n;
                    if (r_closing) begin
                        r_inside <= parity_n;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx   <= idx_inc;
                        r_state <= last ? S_CLOSE : S_FETCH;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobed while sequencer busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    a_fetch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> (r_idx < r_count))
        else $error("vertex fetch beyond stored count");

    a_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> !o_inside_res)
        else $error("dropped append reported as inside");

    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_operation == pipt_pkg::OP_TEST)) |=> o_busy)
        else $error("test transaction did not start the walk");

endmodule
